// ===== hw/rtl/hdpl_pkg.sv =====
// Shared types, sizes and codes for the half-duplex packet link core.
package hdpl_pkg;

    localparam int QUEUE_DEPTH  = 4;
    localparam int PACKET_BYTES = 32;
    localparam int RX_BYTES     = 16;

    localparam int QIDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int FILL_W   = $clog2(PACKET_BYTES + 1);
    localparam int QUEUE_AW = (QUEUE_DEPTH * PACKET_BYTES > 1) ?
                              $clog2(QUEUE_DEPTH * PACKET_BYTES) : 1;
    localparam int RX_AW    = $clog2(RX_BYTES);
    localparam int LEN_W    = 4;
    localparam int LEN_LSB  = 4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_LINE = 1'b1;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_DRIVE = 2'd1;
    localparam logic [1:0] KIND_RX    = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    localparam logic [1:0] SRC_ZERO  = 2'd0;
    localparam logic [1:0] SRC_IN    = 2'd1;
    localparam logic [1:0] SRC_QUEUE = 2'd2;
    localparam logic [1:0] SRC_RX    = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       framing_error;
    } t_in_beat;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       packet_end;
        logic       tx_enabled;
        logic       bad_length;
    } t_out_beat;

    typedef struct packed {
        logic       push_wr;
        logic       set_drop;
        logic       drop_end;
        logic       commit;
        logic       tx_start;
        logic       tx_stop;
        logic       tx_adv;
        logic       pop;
        logic       q_rd;
        logic       rx_hdr;
        logic       rx_wr;
        logic       rx_rd;
        logic       rx_idx_inc;
        logic       rx_clear;
        logic       out_load;
        logic [1:0] out_kind;
        logic [1:0] out_src;
        logic       out_end;
        logic       out_tx_en;
        logic       out_bad;
    } t_cmd;

    typedef struct packed {
        logic dropping;
        logic q_full;
        logic fill_full;
        logic q_empty;
        logic q_one;
        logic tx_active;
        logic tx_last;
        logic rx_idle;
        logic rx_done;
        logic rx_last;
    } t_stat;

endpackage

// ===== hw/rtl/hdpl_datapath.sv =====
// Datapath: packet queue memory, receive buffer, pointers and output register.
module hdpl_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hdpl_pkg::t_cmd    i_cmd,
    input  hdpl_pkg::t_in_beat i_in,
    output hdpl_pkg::t_stat   o_stat,
    output hdpl_pkg::t_out_beat o_out
);
    import hdpl_pkg::*;

    localparam int QMEM_DEPTH = QUEUE_DEPTH * PACKET_BYTES;

    logic [7:0]        r_q_mem [QMEM_DEPTH];
    logic [FILL_W-1:0] r_q_len [QUEUE_DEPTH];
    logic [7:0]        r_rx_mem [RX_BYTES];
    logic [7:0]        r_q_rd;
    logic [7:0]        r_rx_rd;

    logic [QIDX_W-1:0] r_head;
    logic [QIDX_W-1:0] r_tail;
    logic [QCNT_W-1:0] r_count;
    logic [FILL_W-1:0] r_fill;
    logic              r_dropping;
    logic              r_tx_active;
    logic [FILL_W-1:0] r_pos;
    logic [LEN_W-1:0]  r_rx_expected;
    logic [RX_AW-1:0]  r_rx_count;
    logic [RX_AW-1:0]  r_rx_idx;
    t_out_beat         r_out;

    logic [QIDX_W-1:0]   n_head;
    logic [QIDX_W-1:0]   n_tail;
    logic [FILL_W-1:0]   fill_inc;
    logic [FILL_W-1:0]   head_len;
    logic [QUEUE_AW-1:0] wr_addr;
    logic [QUEUE_AW-1:0] rd_addr;
    logic [7:0]          out_byte;

    function automatic logic [QIDX_W-1:0] wrap_next(input logic [QIDX_W-1:0] slot);
        return (slot == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

    function automatic logic [QUEUE_AW-1:0] q_addr(input logic [QIDX_W-1:0] slot,
                                                   input logic [FILL_W-1:0] pos);
        return QUEUE_AW'(QUEUE_AW'(slot) * QUEUE_AW'(PACKET_BYTES) + QUEUE_AW'(pos));
    endfunction

    assign n_head   = wrap_next(r_head);
    assign n_tail   = wrap_next(r_tail);
    assign fill_inc = r_fill + 1'b1;
    assign head_len = r_q_len[r_head];
    assign wr_addr  = q_addr(r_tail, r_fill);
    assign rd_addr  = q_addr(r_head, r_pos);

    // queue memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_q_mem[wr_addr] <= i_in.data_byte;
        end
        if (i_cmd.q_rd) begin
            r_q_rd <= r_q_mem[rd_addr];
        end
        if (i_cmd.commit) begin
            r_q_len[r_tail] <= fill_inc;
        end
    end

    // receive buffer, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_hdr) begin
            r_rx_mem[0] <= i_in.data_byte;
        end else if (i_cmd.rx_wr) begin
            r_rx_mem[r_rx_count] <= i_in.data_byte;
        end
        if (i_cmd.rx_rd) begin
            r_rx_rd <= r_rx_mem[r_rx_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
            r_fill        <= '0;
            r_dropping    <= 1'b0;
            r_tx_active   <= 1'b0;
            r_pos         <= '0;
            r_rx_expected <= '0;
            r_rx_count    <= '0;
            r_rx_idx      <= '0;
        end else begin
            if (i_cmd.set_drop) begin
                r_dropping <= 1'b1;
            end
            if (i_cmd.drop_end) begin
                r_dropping <= 1'b0;
                r_fill     <= '0;
            end else if (i_cmd.commit) begin
                r_fill <= '0;
                r_tail <= n_tail;
            end else if (i_cmd.push_wr) begin
                r_fill <= fill_inc;
            end
            // a commit and a pop never share a cycle
            if (i_cmd.commit) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop) begin
                r_count <= r_count - 1'b1;
                r_head  <= n_head;
            end
            if (i_cmd.tx_start) begin
                r_tx_active <= 1'b1;
                r_pos       <= '0;
            end else if (i_cmd.tx_stop) begin
                r_tx_active <= 1'b0;
                r_pos       <= '0;
            end else if (i_cmd.tx_adv) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.rx_clear) begin
                r_rx_expected <= '0;
                r_rx_count    <= '0;
                r_rx_idx      <= '0;
            end else if (i_cmd.rx_hdr) begin
                r_rx_expected <= i_in.data_byte[LEN_LSB +: LEN_W];
                r_rx_count    <= RX_AW'(1);
                r_rx_idx      <= '0;
            end else begin
                if (i_cmd.rx_wr) begin
                    r_rx_count <= r_rx_count + 1'b1;
                end
                if (i_cmd.rx_idx_inc) begin
                    r_rx_idx <= r_rx_idx + 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (i_cmd.out_src)
            SRC_ZERO:  out_byte = 8'd0;
            SRC_IN:    out_byte = i_in.data_byte;
            SRC_QUEUE: out_byte = r_q_rd;
            SRC_RX:    out_byte = r_rx_rd;
            default:   out_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.kind       <= i_cmd.out_kind;
            r_out.out_byte   <= out_byte;
            r_out.packet_end <= i_cmd.out_end;
            r_out.tx_enabled <= i_cmd.out_tx_en;
            r_out.bad_length <= i_cmd.out_bad;
        end
    end

    assign o_out = r_out;

    assign o_stat.dropping  = r_dropping;
    assign o_stat.q_full    = (r_count >= QCNT_W'(QUEUE_DEPTH));
    assign o_stat.fill_full = (r_fill >= FILL_W'(PACKET_BYTES));
    assign o_stat.q_empty   = (r_count == '0);
    assign o_stat.q_one     = (r_count == QCNT_W'(1));
    assign o_stat.tx_active = r_tx_active;
    assign o_stat.tx_last   = ((FILL_W + 1)'(r_pos) + 1'b1) >= (FILL_W + 1)'(head_len);
    assign o_stat.rx_idle   = (r_rx_expected == '0);
    assign o_stat.rx_done   = ((RX_AW + 1)'(r_rx_count) + 1'b1) >= (RX_AW + 1)'(r_rx_expected);
    assign o_stat.rx_last   = ((RX_AW + 1)'(r_rx_idx) + 1'b1) == (RX_AW + 1)'(r_rx_count);

endmodule

// ===== hw/rtl/hdpl_ctrl.sv =====
// Controller: decodes each input beat and sequences memory reads and result beats.
module hdpl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hdpl_pkg::t_in_beat i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  hdpl_pkg::t_stat    i_stat,
    output hdpl_pkg::t_cmd     o_cmd
);
    import hdpl_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TXRD = 3'd1;
    localparam logic [2:0] S_TXLD = 3'd2;
    localparam logic [2:0] S_RXRD = 3'd3;
    localparam logic [2:0] S_RXLD = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic             r_more;
    logic             n_more;
    logic             accept;
    logic             full_now;
    logic [LEN_W-1:0] hdr_len;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_WAIT);
    assign accept      = i_in_valid && o_in_ready;
    assign full_now    = i_stat.q_full || i_stat.fill_full;
    assign hdr_len     = i_in.data_byte[LEN_LSB +: LEN_W];

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_more  = r_more;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.operation == OP_PUSH) begin
                        if (!i_stat.dropping) begin
                            o_cmd.push_wr  = !full_now;
                            o_cmd.set_drop = full_now;
                        end
                        if (i_in.last_byte) begin
                            if (i_stat.dropping || full_now) begin
                                o_cmd.drop_end  = 1'b1;
                                o_cmd.out_load  = 1'b1;
                                o_cmd.out_kind  = KIND_DROP;
                                o_cmd.out_src   = SRC_ZERO;
                                o_cmd.out_end   = 1'b1;
                                o_cmd.out_tx_en = i_stat.tx_active;
                                n_more          = 1'b0;
                                n_state         = S_WAIT;
                            end else begin
                                o_cmd.commit = 1'b1;
                                if (!i_stat.tx_active) begin
                                    o_cmd.tx_start = 1'b1;
                                    n_state        = S_TXRD;
                                end
                            end
                        end
                    end else if (!i_in.framing_error) begin
                        if (i_stat.tx_active) begin
                            // line byte is the echo of the byte just driven
                            if (i_stat.q_empty || (i_stat.tx_last && i_stat.q_one)) begin
                                o_cmd.pop       = !i_stat.q_empty;
                                o_cmd.tx_stop   = 1'b1;
                                o_cmd.out_load  = 1'b1;
                                o_cmd.out_kind  = KIND_NONE;
                                o_cmd.out_src   = SRC_ZERO;
                                o_cmd.out_end   = 1'b1;
                                o_cmd.out_tx_en = 1'b0;
                                n_more          = 1'b0;
                                n_state         = S_WAIT;
                            end else if (i_stat.tx_last) begin
                                o_cmd.pop      = 1'b1;
                                o_cmd.tx_start = 1'b1;
                                n_state        = S_TXRD;
                            end else begin
                                o_cmd.tx_adv = 1'b1;
                                n_state      = S_TXRD;
                            end
                        end else if (i_stat.rx_idle) begin
                            if (hdr_len == '0) begin
                                o_cmd.out_load  = 1'b1;
                                o_cmd.out_kind  = KIND_NONE;
                                o_cmd.out_src   = SRC_ZERO;
                                o_cmd.out_end   = 1'b1;
                                o_cmd.out_tx_en = i_stat.tx_active;
                                o_cmd.out_bad   = 1'b1;
                                n_more          = 1'b0;
                                n_state         = S_WAIT;
                            end else if (hdr_len == LEN_W'(1)) begin
                                o_cmd.out_load  = 1'b1;
                                o_cmd.out_kind  = KIND_RX;
                                o_cmd.out_src   = SRC_IN;
                                o_cmd.out_end   = 1'b1;
                                o_cmd.out_tx_en = i_stat.tx_active;
                                n_more          = 1'b0;
                                n_state         = S_WAIT;
                            end else begin
                                o_cmd.rx_hdr = 1'b1;
                            end
                        end else begin
                            o_cmd.rx_wr = 1'b1;
                            if (i_stat.rx_done) begin
                                n_state = S_RXRD;
                            end
                        end
                    end
                end
            end
            S_TXRD: begin
                o_cmd.q_rd = 1'b1;
                n_state    = S_TXLD;
            end
            S_TXLD: begin
                o_cmd.out_load  = 1'b1;
                o_cmd.out_kind  = KIND_DRIVE;
                o_cmd.out_src   = SRC_QUEUE;
                o_cmd.out_end   = i_stat.tx_last;
                o_cmd.out_tx_en = 1'b1;
                n_more          = 1'b0;
                n_state         = S_WAIT;
            end
            S_RXRD: begin
                o_cmd.rx_rd = 1'b1;
                n_state     = S_RXLD;
            end
            S_RXLD: begin
                o_cmd.out_load  = 1'b1;
                o_cmd.out_kind  = KIND_RX;
                o_cmd.out_src   = SRC_RX;
                o_cmd.out_end   = i_stat.rx_last;
                o_cmd.out_tx_en = i_stat.tx_active;
                o_cmd.rx_clear  = i_stat.rx_last;
                o_cmd.rx_idx_inc = !i_stat.rx_last;
                n_more          = !i_stat.rx_last;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_ready) begin
                    n_state = r_more ? S_RXRD : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_more  <= n_more;
        end
    end

endmodule

// ===== hw/rtl/half_duplex_packet_link_core.sv =====
// Top level of the half-duplex packet link: controller plus datapath.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) carries one beat per
// event: a byte pushed for an outgoing packet (last_byte closes it) or a byte
// seen on the shared line (framing_error marks it bad). Output channel
// (o_out_valid / i_out_ready, payload o_out) carries result beats: a byte to
// drive, a received packet byte, a drop notice or a status beat.
// One input beat is handled at a time; o_in_ready is high only when the core
// is idle. Beats with no result leave the core idle. A driven byte follows
// the beat that causes it through bookkeeping, a queue memory read and an
// output load, in that order. Drop and status beats appear in the cycle after
// the input beat. A completed received packet of N bytes (up to 15) is sent
// as N beats, each needing a buffer read and an output load; the next read
// waits until the receiver takes the previous beat. The single-port reads of
// the queue and receive memories set this sequence.
// Reset (synchronous, active low) empties the queue, turns the transmitter
// off and clears the deframer; memory contents are not cleared.
// A stalled receiver holds o_out steady and the core accepts no new beat
// until the pending result is taken.
module half_duplex_packet_link_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hdpl_pkg::t_in_beat   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hdpl_pkg::t_out_beat  o_out
);
    import hdpl_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    hdpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    hdpl_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule

// ===== bench/hdpl_link_checker.sv =====
// Scoreboard for the half-duplex packet link core: predicts result beats and compares them.
`timescale 1ns / 1ps

module hdpl_link_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  hdpl_pkg::t_in_beat  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  hdpl_pkg::t_out_beat i_out,
    output int                  o_fail_count,
    output int                  o_waiting
);
    import hdpl_pkg::*;

    // outgoing packet queue
    logic [7:0]        txq_bytes [QUEUE_DEPTH*PACKET_BYTES];
    logic [FILL_W-1:0] txq_lens  [QUEUE_DEPTH];
    logic [QIDX_W-1:0] txq_head;
    logic [QIDX_W-1:0] txq_tail;
    logic [QCNT_W-1:0] txq_count;
    logic [FILL_W-1:0] push_fill;
    logic              push_drop;
    logic              tx_on;
    logic [FILL_W-1:0] tx_pos;

    // deframer
    logic [7:0]        rx_bytes [RX_BYTES];
    logic [LEN_W-1:0]  rx_need;
    logic [RX_AW-1:0]  rx_got;

    t_out_beat         link_results[$];
    int                mismatches = 0;

    function automatic logic [QIDX_W-1:0] next_slot(logic [QIDX_W-1:0] slot);
        return (int'(slot) + 1 >= QUEUE_DEPTH) ? '0 : slot + 1'b1;
    endfunction

    function automatic int txq_addr(logic [QIDX_W-1:0] slot, logic [FILL_W-1:0] pos);
        return int'(slot) * PACKET_BYTES + int'(pos);
    endfunction

    // tx_enabled always reflects the transmitter state at the moment of the result
    function automatic void add_result(logic [1:0] kind, logic [7:0] data, logic last,
                                       logic bad);
        t_out_beat res;
        res.kind       = kind;
        res.out_byte   = data;
        res.packet_end = last;
        res.tx_enabled = tx_on;
        res.bad_length = bad;
        link_results = {link_results, res};
    endfunction

    function automatic void start_head();
        tx_on  = 1'b1;
        tx_pos = '0;
        add_result(KIND_DRIVE, txq_bytes[txq_addr(txq_head, '0)], txq_lens[txq_head] <= 1,
                   1'b0);
    endfunction

    function automatic void tx_off_status();
        tx_on  = 1'b0;
        tx_pos = '0;
        add_result(KIND_NONE, 8'h00, 1'b1, 1'b0);
    endfunction

    function automatic void predict_push(logic [7:0] data, logic last);
        if (!push_drop) begin
            if (int'(txq_count) >= QUEUE_DEPTH || int'(push_fill) >= PACKET_BYTES) begin
                push_drop = 1'b1;
            end else begin
                txq_bytes[txq_addr(txq_tail, push_fill)] = data;
                push_fill++;
            end
        end
        if (!last) return;
        if (push_drop) begin
            push_drop = 1'b0;
            push_fill = '0;
            add_result(KIND_DROP, 8'h00, 1'b1, 1'b0);
            return;
        end
        txq_lens[txq_tail] = push_fill;
        txq_tail = next_slot(txq_tail);
        txq_count++;
        push_fill = '0;
        if (!tx_on) start_head();
    endfunction

    function automatic void predict_echo();
        if (txq_count == 0) begin
            tx_off_status();
            return;
        end
        tx_pos++;
        if (tx_pos >= txq_lens[txq_head]) begin
            txq_head = next_slot(txq_head);
            txq_count--;
            if (txq_count == 0) tx_off_status();
            else start_head();
            return;
        end
        add_result(KIND_DRIVE, txq_bytes[txq_addr(txq_head, tx_pos)],
                   int'(tx_pos) + 1 >= int'(txq_lens[txq_head]), 1'b0);
    endfunction

    function automatic void predict_receive(logic [7:0] data);
        logic [LEN_W-1:0] hdr_len;
        if (rx_need == 0) begin
            hdr_len = data[LEN_LSB +: LEN_W];
            if (hdr_len == 0) begin
                add_result(KIND_NONE, 8'h00, 1'b1, 1'b1);
            end else if (hdr_len == 1) begin
                add_result(KIND_RX, data, 1'b1, 1'b0);
            end else begin
                rx_bytes[0] = data;
                rx_got      = RX_AW'(1);
                rx_need     = hdr_len;
            end
            return;
        end
        rx_bytes[rx_got] = data;
        rx_got++;
        if (rx_got < rx_need) return;
        for (int i = 0; i < int'(rx_got); i++) begin
            add_result(KIND_RX, rx_bytes[i], i + 1 == int'(rx_got), 1'b0);
        end
        rx_need = '0;
        rx_got  = '0;
    endfunction

    function automatic void compare_field(string field, logic [7:0] want, logic [7:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, seen);
            mismatches++;
        end
    endfunction

    function automatic void check_result(t_out_beat seen);
        t_out_beat want;
        if (link_results.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %p", $time, seen);
            mismatches++;
            return;
        end
        want = link_results[0];
        link_results.delete(0);
        compare_field("kind",       8'(want.kind),       8'(seen.kind));
        compare_field("out_byte",   want.out_byte,       seen.out_byte);
        compare_field("packet_end", 8'(want.packet_end), 8'(seen.packet_end));
        compare_field("tx_enabled", 8'(want.tx_enabled), 8'(seen.tx_enabled));
        compare_field("bad_length", 8'(want.bad_length), 8'(seen.bad_length));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            txq_head  = '0;
            txq_tail  = '0;
            txq_count = '0;
            push_fill = '0;
            push_drop = 1'b0;
            tx_on     = 1'b0;
            tx_pos    = '0;
            rx_need   = '0;
            rx_got    = '0;
            link_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_in.operation == OP_PUSH) predict_push(i_in.data_byte, i_in.last_byte);
                else if (i_in.framing_error) ;
                else if (tx_on) predict_echo();
                else predict_receive(i_in.data_byte);
            end
            if (i_out_valid && i_out_ready) check_result(i_out);
        end
        o_waiting    <= link_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/tb_half_duplex_packet_link_core.sv =====
// Testbench top for the half-duplex packet link core: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb_half_duplex_packet_link_core;
    import hdpl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASE_ITEMS    = 75;
    localparam int PHASES         = 4;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;

    int fail_count;
    int waiting;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int items_sent  = 0;
    int idle_cycles = 0;

    // lengths of outgoing packets still on the queue, and echoes seen for the head one
    int queued_lens[$];
    int head_echoes = 0;

    always #5 clk = ~clk;

    half_duplex_packet_link_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    hdpl_link_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_beat),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always @(posedge clk) begin
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(logic op, logic [7:0] data, logic last, logic ferr);
        t_in_beat beat;
        logic     took;
        beat.operation     = op;
        beat.data_byte     = data;
        beat.last_byte     = last;
        beat.framing_error = ferr;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_beat  <= beat;
        in_valid <= 1'b1;
        // ready sampled mid-cycle holds its value at the next rising edge
        do begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
        items_sent++;
    endtask

    // echo of the byte being driven, sometimes after a bad-stop-bit byte
    task automatic echo_beat();
        if ($urandom_range(9) == 0) send_beat(OP_LINE, 8'($urandom), 1'($urandom), 1'b1);
        send_beat(OP_LINE, 8'($urandom), 1'($urandom), 1'b0);
        head_echoes++;
        if (head_echoes == queued_lens[0]) begin
            queued_lens.delete(0);
            head_echoes = 0;
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (waiting != 0);
        @(posedge clk);
    endtask

    initial begin
        int pick;
        int len;
        int sent_to;
        int packets;
        int target;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // deframer: zero length, length one, framing error, short packet
        send_beat(OP_LINE, 8'h0F, 1'b0, 1'b0);
        send_beat(OP_LINE, 8'h1A, 1'b1, 1'b0);
        send_beat(OP_LINE, 8'hFF, 1'b0, 1'b1);
        send_beat(OP_LINE, 8'h3C, 1'b0, 1'b0);
        send_beat(OP_LINE, 8'h00, 1'b1, 1'b0);
        send_beat(OP_LINE, 8'hFF, 1'b0, 1'b0);
        // single byte packet, then its echo turns tx off
        send_beat(OP_PUSH, 8'hA5, 1'b1, 1'b1);
        send_beat(OP_LINE, 8'hA5, 1'b0, 1'b0);
        // two packets back to back, bad byte in the middle of transmission
        send_beat(OP_PUSH, 8'h00, 1'b0, 1'b0);
        send_beat(OP_PUSH, 8'hFF, 1'b1, 1'b0);
        send_beat(OP_PUSH, 8'h81, 1'b1, 1'b0);
        send_beat(OP_LINE, 8'h00, 1'b0, 1'b0);
        send_beat(OP_LINE, 8'h55, 1'b1, 1'b1);
        send_beat(OP_LINE, 8'hFF, 1'b0, 1'b0);
        send_beat(OP_LINE, 8'h81, 1'b0, 1'b0);
        // fill the queue; the fifth packet is dropped
        for (int i = 0; i < QUEUE_DEPTH + 1; i++) send_beat(OP_PUSH, 8'(i * 8'h11), 1'b1, i[0]);
        for (int i = 0; i < QUEUE_DEPTH; i++) send_beat(OP_LINE, 8'h00, 1'b0, 1'b0);
        wait_all_results();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 85; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 85; end
                default: begin gap_pct = 9; stall_pct = 9; end
            endcase
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    // transmit session: a few packets, echoes interleaved, then drained
                    packets = $urandom_range(6, 1);
                    repeat (packets) begin
                        pick = $urandom_range(99);
                        if (pick < 70) len = $urandom_range(6, 1);
                        else if (pick < 92) len = $urandom_range(PACKET_BYTES, 7);
                        else len = $urandom_range(PACKET_BYTES + 3, PACKET_BYTES + 1);
                        for (int k = 0; k < len; k++) begin
                            send_beat(OP_PUSH, 8'($urandom), k == len - 1, 1'($urandom));
                        end
                        if (len <= PACKET_BYTES && queued_lens.size() < QUEUE_DEPTH) begin
                            queued_lens = {queued_lens, len};
                        end
                        if (queued_lens.size() != 0 && $urandom_range(3) == 0) echo_beat();
                    end
                    while (queued_lens.size() != 0) echo_beat();
                end else if (pick < 88) begin
                    // received packet, now and then cut short
                    len = ($urandom_range(99) < 8) ? $urandom_range(1) : $urandom_range(15, 2);
                    sent_to = len;
                    if (len > 1 && $urandom_range(9) == 0) sent_to = $urandom_range(len - 1, 1);
                    send_beat(OP_LINE, {4'(len), 4'($urandom)}, 1'($urandom), 1'b0);
                    for (int k = 1; k < sent_to; k++) begin
                        if ($urandom_range(99) < 8) begin
                            send_beat(OP_LINE, 8'($urandom), 1'($urandom), 1'b1);
                        end
                        send_beat(OP_LINE, 8'($urandom), 1'($urandom), 1'b0);
                    end
                end else begin
                    repeat ($urandom_range(4, 1)) begin
                        send_beat(OP_LINE, 8'($urandom), 1'($urandom), 1'($urandom));
                    end
                end
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/hdpl_pkg.sv
hw/rtl/hdpl_datapath.sv
hw/rtl/hdpl_ctrl.sv
hw/rtl/half_duplex_packet_link_core.sv
bench/hdpl_link_checker.sv
bench/tb_half_duplex_packet_link_core.sv
